@@ rtl/core/upd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and helper functions of the URI percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int          SEQ_DEPTH   = 4;
  localparam int          SEQ_IDX_W   = $clog2(SEQ_DEPTH);
  localparam int          QUEUE_DEPTH = 2;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  PCT_CHAR    = 8'h25;
  localparam logic [7:0]  LEAD4_MASK  = 8'hf8;
  localparam logic [7:0]  LEAD4_CODE  = 8'hf0;
  localparam logic [7:0]  LEAD3_MASK  = 8'hf0;
  localparam logic [7:0]  LEAD3_CODE  = 8'he0;
  localparam logic [7:0]  LEAD2_MASK  = 8'he0;
  localparam logic [7:0]  LEAD2_CODE  = 8'hc0;
  localparam logic [7:0]  CONT_MASK   = 8'hc0;
  localparam logic [7:0]  CONT_CODE   = 8'h80;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t [SEQ_DEPTH-1:0]   bytes;
    logic  [SEQ_IDX_W-1:0]   last;
    logic                    eos;
    logic                    malformed;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input byte_t c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {["0":"9"]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      h.val = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_reserved(input byte_t b);
    return b inside {";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#"};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/upd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded words, tracks escapes and sequences, and issues one
// command per result group to the queue.
// ----------------------------------------------------------------------------
module upd_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic         cfg_wdata,
  input  wire logic         in_valid,
  input  wire logic         in_stall,
  input  wire logic [7:0]   char_byte,
  input  wire logic         is_final,
  output upd_pkg::cmd_t     push_cmd,
  output logic              push
);
  import upd_pkg::*;

  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_HEX1,
    PH_HEX2,
    PH_CONT_PCT,
    PH_CONT_HEX1,
    PH_CONT_HEX2
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   keep_reserved;
  byte_t                  first_hex_char, first_hex_char_next;
  logic [1:0]             pending, pending_next;
  byte_t [SEQ_DEPTH-1:0]  seq_bytes, seq_bytes_next;
  logic [2:0]             seq_count, seq_count_next;
  logic                   swallowing, swallowing_next;

  logic                   fire;
  hex_t                   hc, h1;
  byte_t                  dec;

  assign fire = in_valid && !in_stall;
  assign hc   = hex_digit(char_byte);
  assign h1   = hex_digit(first_hex_char);
  assign dec  = {h1.val, hc.val};

  always_comb begin
    phase_next          = phase;
    first_hex_char_next = first_hex_char;
    pending_next        = pending;
    seq_bytes_next      = seq_bytes;
    seq_count_next      = seq_count;
    swallowing_next     = swallowing;
    push                = 1'b0;
    push_cmd.bytes      = seq_bytes;
    push_cmd.last       = '0;
    push_cmd.eos        = is_final;
    push_cmd.malformed  = 1'b0;
    if (fire) begin
      if (swallowing) begin
        if (is_final) begin
          swallowing_next = 1'b0;
        end
      end else begin
        case (phase)
          PH_HEX1, PH_CONT_HEX1: begin
            if (hc.ok && !is_final) begin
              first_hex_char_next = char_byte;
              phase_next = (phase == PH_HEX1) ? PH_HEX2 : PH_CONT_HEX2;
            end else begin
              push_cmd.malformed = 1'b1;
            end
          end
          PH_HEX2: begin
            if (!hc.ok || !h1.ok) begin
              push_cmd.malformed = 1'b1;
            end else if (dec[7]) begin
              if ((dec & LEAD4_MASK) == LEAD4_CODE) begin
                pending_next = 2'd3;
              end else if ((dec & LEAD3_MASK) == LEAD3_CODE) begin
                pending_next = 2'd2;
              end else begin
                pending_next = 2'd1;
              end
              if (((dec & LEAD2_MASK) != LEAD2_CODE) && ((dec & LEAD3_MASK) != LEAD3_CODE)
                  && ((dec & LEAD4_MASK) != LEAD4_CODE)) begin
                push_cmd.malformed = 1'b1;
              end else if (is_final) begin
                push_cmd.malformed = 1'b1;
              end else begin
                seq_bytes_next[0] = dec;
                seq_count_next    = 3'd1;
                phase_next        = PH_CONT_PCT;
              end
            end else begin
              phase_next = PH_PLAIN;
              push       = 1'b1;
              if (keep_reserved && is_reserved(dec)) begin
                push_cmd.bytes[0] = PCT_CHAR;
                push_cmd.bytes[1] = first_hex_char;
                push_cmd.bytes[2] = char_byte;
                push_cmd.last     = SEQ_IDX_W'(2);
              end else begin
                push_cmd.bytes[0] = dec;
              end
            end
          end
          PH_CONT_PCT: begin
            if (char_byte == PCT_CHAR && !is_final) begin
              phase_next = PH_CONT_HEX1;
            end else begin
              push_cmd.malformed = 1'b1;
            end
          end
          PH_CONT_HEX2: begin
            if (!hc.ok || !h1.ok || ((dec & CONT_MASK) != CONT_CODE)) begin
              push_cmd.malformed = 1'b1;
            end else if (pending != 2'd1) begin
              if (is_final) begin
                push_cmd.malformed = 1'b1;
              end else begin
                seq_bytes_next[seq_count[SEQ_IDX_W-1:0]] = dec;
                seq_count_next = seq_count + 3'd1;
                pending_next   = pending - 2'd1;
                phase_next     = PH_CONT_PCT;
              end
            end else begin
              push_cmd.bytes[seq_count[SEQ_IDX_W-1:0]] = dec;
              push_cmd.last  = seq_count[SEQ_IDX_W-1:0];
              push           = 1'b1;
              pending_next   = 2'd0;
              seq_count_next = 3'd0;
              phase_next     = PH_PLAIN;
            end
          end
          default: begin
            phase_next = PH_PLAIN;
            if (char_byte == PCT_CHAR) begin
              if (is_final) begin
                push_cmd.malformed = 1'b1;
              end else begin
                phase_next = PH_HEX1;
              end
            end else begin
              push              = 1'b1;
              push_cmd.bytes[0] = char_byte;
            end
          end
        endcase
        if (push_cmd.malformed) begin
          push            = 1'b1;
          push_cmd.bytes  = '0;
          push_cmd.last   = '0;
          push_cmd.eos    = 1'b1;
          phase_next      = PH_PLAIN;
          pending_next    = 2'd0;
          seq_count_next  = 3'd0;
          swallowing_next = !is_final;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PLAIN;
      keep_reserved <= 1'b0;
      pending       <= 2'd0;
      seq_count     <= 3'd0;
      swallowing    <= 1'b0;
    end else begin
      phase      <= phase_next;
      pending    <= pending_next;
      seq_count  <= seq_count_next;
      swallowing <= swallowing_next;
      if (cfg_wen) begin
        keep_reserved <= cfg_wdata;
      end
    end
    first_hex_char <= first_hex_char_next;
    seq_bytes      <= seq_bytes_next;
  end

endmodule
`default_nettype wire

@@ rtl/core/upd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// upd_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire upd_pkg::cmd_t push_cmd,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output upd_pkg::cmd_t     head_cmd
);
  import upd_pkg::*;

  cmd_t                    entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/upd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// upd_back
// Takes commands from the queue and sends their result words one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module upd_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire upd_pkg::cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_byte,
  output logic              malformed,
  output logic              end_of_string
);
  import upd_pkg::*;

  cmd_t                  cur;
  logic                  busy;
  logic [SEQ_IDX_W-1:0]  idx;
  logic                  at_last;
  logic                  fire;

  assign at_last       = (idx == cur.last);
  assign fire          = busy && !out_stall;
  assign pop           = head_valid && (!busy || (fire && at_last));
  assign out_valid     = busy;
  assign out_byte      = cur.bytes[idx];
  assign malformed     = cur.malformed;
  assign end_of_string = cur.eos && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (fire) begin
        if (at_last) begin
          busy <= 1'b0;
          idx  <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
    if (pop) begin
      cur <= head_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/uri_percent_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uri_percent_decoder
// Streaming URI percent decoder with UTF-8 escape checking.
// ----------------------------------------------------------------------------
// The decoder takes one encoded word per cycle while in_stall is low and
// sends decoded words one per cycle while out_stall is low. A plain byte or
// a simple escape gives one result word, a kept reserved escape three and a
// multi-byte sequence two to four, all sent from a registered output stage.
// Each command passes from the command queue into that output register.
// A two-entry command queue sits between the input side and the output side,
// so input is stalled only while the queue is full, which happens when
// multi-word results drain slower than input arrives or when the output is
// stalled. A malformed escape gives one word with malformed and end_of_string
// set; later input words up to the end of the string give no result. Write
// keep_reserved only while the block is idle.
module uri_percent_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic         cfg_wdata,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   char_byte,
  input  wire logic         is_final,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_byte,
  output logic              malformed,
  output logic              end_of_string
);
  import upd_pkg::*;

  cmd_t  push_cmd, head_cmd;
  logic  push, full, pop, head_valid;

  assign in_stall = full;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_byte (char_byte),
    .is_final  (is_final),
    .push_cmd  (push_cmd),
    .push      (push)
  );

  upd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  upd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .malformed     (malformed),
    .end_of_string (end_of_string)
  );

endmodule
`default_nettype wire
